// ===== rtl/sald_pkg.sv =====
// Shared types and constants for the server address list deframer.
`timescale 1ns / 1ps

package sald_pkg;

    localparam int COUNT_W = 5;
    localparam int PHASE_W = 3;
    localparam int STATUS_W = 3;

    localparam logic [7:0] PREFIX_IPV4 = 8'h5C;
    localparam logic [7:0] PREFIX_IPV6 = 8'h2F;

    localparam logic [COUNT_W-1:0] IPV4_BYTES = 5'd4;
    localparam logic [COUNT_W-1:0] IPV6_BYTES = 5'd16;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADPREFIX = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZEROPORT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } sald_item_t;

    typedef struct packed {
        logic                is_record;
        logic                is_ipv6;
        logic [63:0]         address_high;
        logic [63:0]         address_low;
        logic [15:0]         port;
        logic [STATUS_W-1:0] status;
        logic                last;
    } sald_result_t;

    typedef struct packed {
        logic [1:0]   count;
        sald_result_t first;
        sald_result_t second;
    } sald_push_t;

endpackage

// ===== rtl/sald_parser.sv =====
// Byte parser that walks the header and address records and builds result beats.
`timescale 1ns / 1ps

module sald_parser #(
    parameter int HEADER_BYTES = 22
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                enable,
    input  sald_pkg::sald_item_t item,
    output sald_pkg::sald_push_t push
);

    localparam logic [sald_pkg::PHASE_W-1:0] PH_HEADER = 3'd0;
    localparam logic [sald_pkg::PHASE_W-1:0] PH_PREFIX = 3'd1;
    localparam logic [sald_pkg::PHASE_W-1:0] PH_ADDR   = 3'd2;
    localparam logic [sald_pkg::PHASE_W-1:0] PH_PORT0  = 3'd3;
    localparam logic [sald_pkg::PHASE_W-1:0] PH_PORT1  = 3'd4;
    localparam logic [sald_pkg::PHASE_W-1:0] PH_STOP   = 3'd5;

    localparam logic [sald_pkg::PHASE_W-1:0] PH_START =
        (HEADER_BYTES == 0) ? PH_PREFIX : PH_HEADER;
    localparam logic [sald_pkg::COUNT_W-1:0] HEADER_LEN =
        sald_pkg::COUNT_W'(HEADER_BYTES);

    logic [sald_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [sald_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          ipv6_reg, ipv6_next;
    logic [63:0]                   addr_high_reg, addr_high_next;
    logic [63:0]                   addr_low_reg, addr_low_next;
    logic [7:0]                    port_first_reg, port_first_next;
    logic [sald_pkg::STATUS_W-1:0] stop_reg, stop_next;

    logic [sald_pkg::COUNT_W-1:0]  count_inc;
    logic [sald_pkg::COUNT_W-1:0]  addr_len;
    logic [15:0]                   port_value;
    logic [sald_pkg::STATUS_W-1:0] end_status;
    logic                          record_out;
    sald_pkg::sald_result_t        record_item;
    sald_pkg::sald_result_t        status_item;

    assign count_inc  = count_reg + sald_pkg::COUNT_W'(1);
    assign addr_len   = ipv6_reg ? sald_pkg::IPV6_BYTES : sald_pkg::IPV4_BYTES;
    assign port_value = {item.data_byte, port_first_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        ipv6_next       = ipv6_reg;
        addr_high_next  = addr_high_reg;
        addr_low_next   = addr_low_reg;
        port_first_next = port_first_reg;
        stop_next       = stop_reg;
        end_status      = sald_pkg::ST_OK;
        record_out      = 1'b0;

        if (!enable)
        begin
            end_status = sald_pkg::ST_IGNORED;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (count_inc >= HEADER_LEN)
                    begin
                        phase_next = PH_PREFIX;
                        count_next = '0;
                        end_status = sald_pkg::ST_OK;
                    end
                    else
                    begin
                        count_next = count_inc;
                        end_status = sald_pkg::ST_SHORT;
                    end
                end
                PH_PREFIX:
                begin
                    if (item.data_byte == sald_pkg::PREFIX_IPV4 ||
                        item.data_byte == sald_pkg::PREFIX_IPV6)
                    begin
                        ipv6_next      = (item.data_byte == sald_pkg::PREFIX_IPV6);
                        addr_high_next = '0;
                        addr_low_next  = '0;
                        count_next     = '0;
                        phase_next     = PH_ADDR;
                        end_status     = sald_pkg::ST_TRUNC;
                    end
                    else
                    begin
                        stop_next  = sald_pkg::ST_BADPREFIX;
                        phase_next = PH_STOP;
                        end_status = sald_pkg::ST_BADPREFIX;
                    end
                end
                PH_ADDR:
                begin
                    addr_high_next = {addr_high_reg[55:0], addr_low_reg[63:56]};
                    addr_low_next  = {addr_low_reg[55:0], item.data_byte};
                    count_next     = count_inc;
                    if (count_inc >= addr_len)
                    begin
                        phase_next = PH_PORT0;
                    end
                    end_status = sald_pkg::ST_TRUNC;
                end
                PH_PORT0:
                begin
                    port_first_next = item.data_byte;
                    phase_next      = PH_PORT1;
                    end_status      = sald_pkg::ST_TRUNC;
                end
                PH_PORT1:
                begin
                    if (port_value == 16'd0)
                    begin
                        stop_next  = sald_pkg::ST_ZEROPORT;
                        phase_next = PH_STOP;
                        end_status = sald_pkg::ST_ZEROPORT;
                    end
                    else
                    begin
                        record_out = 1'b1;
                        phase_next = PH_PREFIX;
                        count_next = '0;
                        end_status = sald_pkg::ST_OK;
                    end
                end
                default:
                begin
                    phase_next = PH_STOP;
                    end_status = stop_reg;
                end
            endcase
        end

        if (item.end_of_packet)
        begin
            phase_next      = PH_START;
            count_next      = '0;
            ipv6_next       = 1'b0;
            addr_high_next  = '0;
            addr_low_next   = '0;
            port_first_next = '0;
            stop_next       = sald_pkg::ST_OK;
        end
    end

    always_comb
    begin
        record_item              = '0;
        record_item.is_record    = 1'b1;
        record_item.is_ipv6      = ipv6_reg;
        record_item.address_high = addr_high_reg;
        record_item.address_low  = addr_low_reg;
        record_item.port         = port_value;
        record_item.status       = sald_pkg::ST_OK;

        status_item        = '0;
        status_item.status = end_status;
        status_item.last   = 1'b1;

        push = '0;
        if (accept)
        begin
            priority if (record_out && item.end_of_packet)
            begin
                push.count  = 2'd2;
                push.first  = record_item;
                push.second = status_item;
            end
            else if (record_out)
            begin
                push.count = 2'd1;
                push.first = record_item;
            end
            else if (item.end_of_packet)
            begin
                push.count = 2'd1;
                push.first = status_item;
            end
            else
            begin
                push.count = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            count_reg      <= '0;
            ipv6_reg       <= 1'b0;
            addr_high_reg  <= '0;
            addr_low_reg   <= '0;
            port_first_reg <= '0;
            stop_reg       <= sald_pkg::ST_OK;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            ipv6_reg       <= ipv6_next;
            addr_high_reg  <= addr_high_next;
            addr_low_reg   <= addr_low_next;
            port_first_reg <= port_first_next;
            stop_reg       <= stop_next;
        end
    end

endmodule

// ===== rtl/sald_fifo.sv =====
// Four-entry result queue that takes up to two beats per cycle and gives one per cycle unless result_stall holds it.
`timescale 1ns / 1ps

module sald_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sald_pkg::sald_push_t   push,
    output logic                   almost_full,
    output logic                   result_valid,
    input  logic                   result_stall,
    output sald_pkg::sald_result_t result
);

    sald_pkg::sald_result_t entry_reg [4];

    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] fill_reg, fill_next;
    logic       pop;
    logic [1:0] wr_ptr_plus;

    assign pop          = (fill_reg != 3'd0) && !result_stall;
    assign wr_ptr_plus  = wr_ptr_reg + 2'd1;
    assign wr_ptr_next  = wr_ptr_reg + push.count;
    assign rd_ptr_next  = rd_ptr_reg + {1'b0, pop};
    assign fill_next    = fill_reg + {1'b0, push.count} - {2'b00, pop};
    assign almost_full  = (fill_reg > 3'd2);
    assign result_valid = (fill_reg != 3'd0);
    assign result       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/server_address_list_deframer.sv =====
// Top level of the server address list deframer.
// Result beats are registered in the result queue before they are offered.
// Throughput: one byte per cycle while item_stall is low; a record that ends on the final byte adds a status beat.
// Bytes stall while the four-entry result queue holds more than two beats.
// Reset clears the parser to its start state, empties the queue and clears the enable.
`timescale 1ns / 1ps

module server_address_list_deframer #(
    parameter int HEADER_BYTES = 22
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic                   cfg_data,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  sald_pkg::sald_item_t   item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output sald_pkg::sald_result_t result
);

    logic                 accept_enable_reg;
    logic                 accept_enable_next;
    logic                 almost_full;
    logic                 accept;
    sald_pkg::sald_push_t push;

    assign item_stall         = almost_full;
    assign accept             = item_valid && !almost_full;
    assign accept_enable_next = cfg_write ? cfg_data : accept_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_enable_reg <= 1'b0;
        end
        else
        begin
            accept_enable_reg <= accept_enable_next;
        end
    end

    sald_parser #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .enable (accept_enable_reg),
        .item   (item),
        .push   (push)
    );

    sald_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .almost_full  (almost_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the server address list deframer, with directed and random packets.
`timescale 1ns / 1ps

module tb_top;

    localparam int HEADER_BYTES = 22;
    localparam int RANDOM_BYTES = 1750;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PREFIX,
        PH_ADDR,
        PH_PORT0,
        PH_PORT1,
        PH_STOP
    } parse_phase_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic                   cfg_data = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    sald_pkg::sald_item_t   item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    sald_pkg::sald_result_t result;

    parse_phase_t parse_phase;
    logic [4:0]   byte_idx;
    logic         rec_v6;
    logic [63:0]  addr_hi;
    logic [63:0]  addr_lo;
    logic [7:0]   port_lo_byte;
    logic [2:0]   stop_code;
    logic         accept_en;

    sald_pkg::sald_result_t predicted_beats[$];
    logic [7:0]             pkt_q[$];

    int idle_max = 12;
    int stall_max = 12;
    int error_count = 0;
    int bytes_parsed = 0;
    int packets_sent = 0;
    int records_seen = 0;
    int status_seen = 0;

    server_address_list_deframer #(
        .HEADER_BYTES(HEADER_BYTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL server_address_list_deframer");
        $finish;
    end

    function automatic sald_pkg::sald_result_t status_beat(input logic [2:0] code);
        sald_pkg::sald_result_t beat;
        beat = '0;
        beat.status = code;
        beat.last = 1'b1;
        return beat;
    endfunction

    task automatic restart_parse();
        parse_phase = (HEADER_BYTES == 0) ? PH_PREFIX : PH_HEADER;
        byte_idx = '0;
        rec_v6 = 1'b0;
        addr_hi = '0;
        addr_lo = '0;
        port_lo_byte = '0;
        stop_code = sald_pkg::ST_OK;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eop);
        logic [2:0]             end_code;
        sald_pkg::sald_result_t beat;
        end_code = sald_pkg::ST_OK;
        if (!accept_en)
        begin
            if (eop)
            begin
                predicted_beats.push_back(status_beat(sald_pkg::ST_IGNORED));
                restart_parse();
            end
        end
        else
        begin
            bytes_parsed++;
            case (parse_phase)
                PH_HEADER:
                begin
                    byte_idx = byte_idx + 5'd1;
                    if (byte_idx >= HEADER_BYTES)
                    begin
                        parse_phase = PH_PREFIX;
                        byte_idx = '0;
                    end
                    end_code = (parse_phase == PH_HEADER) ? sald_pkg::ST_SHORT
                                                          : sald_pkg::ST_OK;
                end
                PH_PREFIX:
                begin
                    if (b == sald_pkg::PREFIX_IPV4 || b == sald_pkg::PREFIX_IPV6)
                    begin
                        rec_v6 = (b == sald_pkg::PREFIX_IPV6);
                        addr_hi = '0;
                        addr_lo = '0;
                        byte_idx = '0;
                        parse_phase = PH_ADDR;
                        end_code = sald_pkg::ST_TRUNC;
                    end
                    else
                    begin
                        stop_code = sald_pkg::ST_BADPREFIX;
                        parse_phase = PH_STOP;
                        end_code = sald_pkg::ST_BADPREFIX;
                    end
                end
                PH_ADDR:
                begin
                    addr_hi = {addr_hi[55:0], addr_lo[63:56]};
                    addr_lo = {addr_lo[55:0], b};
                    byte_idx = byte_idx + 5'd1;
                    if (byte_idx >= (rec_v6 ? sald_pkg::IPV6_BYTES : sald_pkg::IPV4_BYTES))
                        parse_phase = PH_PORT0;
                    end_code = sald_pkg::ST_TRUNC;
                end
                PH_PORT0:
                begin
                    port_lo_byte = b;
                    parse_phase = PH_PORT1;
                    end_code = sald_pkg::ST_TRUNC;
                end
                PH_PORT1:
                begin
                    if ({b, port_lo_byte} == 16'h0000)
                    begin
                        stop_code = sald_pkg::ST_ZEROPORT;
                        parse_phase = PH_STOP;
                        end_code = sald_pkg::ST_ZEROPORT;
                    end
                    else
                    begin
                        beat = '0;
                        beat.is_record = 1'b1;
                        beat.is_ipv6 = rec_v6;
                        beat.address_high = addr_hi;
                        beat.address_low = addr_lo;
                        beat.port = {b, port_lo_byte};
                        predicted_beats.push_back(beat);
                        parse_phase = PH_PREFIX;
                        byte_idx = '0;
                        end_code = sald_pkg::ST_OK;
                    end
                end
                default:
                begin
                    parse_phase = PH_STOP;
                    end_code = stop_code;
                end
            endcase
            if (eop)
            begin
                predicted_beats.push_back(status_beat(end_code));
                restart_parse();
            end
        end
    endtask

    task automatic check_result(input sald_pkg::sald_result_t got);
        sald_pkg::sald_result_t want;
        if (predicted_beats.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("Unexpected result beat: rec=%0d v6=%0d hi=%h lo=%h port=%h st=%0d last=%0d",
                         got.is_record, got.is_ipv6, got.address_high, got.address_low,
                         got.port, got.status, got.last);
        end
        else
        begin
            want = predicted_beats.pop_front();
            if (want.is_record)
                records_seen++;
            else
                status_seen++;
            if (got.is_record !== want.is_record || got.is_ipv6 !== want.is_ipv6 ||
                got.address_high !== want.address_high ||
                got.address_low !== want.address_low || got.port !== want.port ||
                got.status !== want.status || got.last !== want.last)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("Mismatch, expected: rec=%0d v6=%0d hi=%h lo=%h port=%h st=%0d last=%0d",
                             want.is_record, want.is_ipv6, want.address_high,
                             want.address_low, want.port, want.status, want.last);
                    $display("           actual: rec=%0d v6=%0d hi=%h lo=%h port=%h st=%0d last=%0d",
                             got.is_record, got.is_ipv6, got.address_high,
                             got.address_low, got.port, got.status, got.last);
                end
            end
        end
    endtask

    initial
    begin : result_sink
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                check_result(result);
                hold = $urandom_range(0, stall_max);
            end
            else if (hold > 0)
            begin
                hold--;
            end
            result_stall <= (hold > 0);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eop);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{data_byte: b, end_of_packet: eop};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        parse_byte(b, eop);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (predicted_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_enable(input logic en);
        cfg_write <= 1'b1;
        cfg_data <= en;
        @(posedge clk);
        cfg_write <= 1'b0;
        accept_en = en;
        @(posedge clk);
    endtask

    task automatic add_noise(input int n);
        repeat (n) pkt_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_record(input logic v6, input logic [127:0] addr,
                              input logic [15:0] port);
        pkt_q.push_back(v6 ? sald_pkg::PREFIX_IPV6 : sald_pkg::PREFIX_IPV4);
        for (int i = (v6 ? 15 : 3); i >= 0; i--)
            pkt_q.push_back(addr[i*8 +: 8]);
        pkt_q.push_back(port[7:0]);
        pkt_q.push_back(port[15:8]);
    endtask

    task automatic add_random_record();
        logic [127:0] addr;
        logic [15:0]  port;
        case ($urandom_range(0, 9))
            0: addr = '0;
            1: addr = '1;
            default: addr = {$urandom, $urandom, $urandom, $urandom};
        endcase
        case ($urandom_range(0, 9))
            0: port = 16'h0001;
            1: port = 16'hFFFF;
            2: port = {8'($urandom_range(1, 255)), 8'h00};
            default: port = 16'($urandom_range(1, 65535));
        endcase
        add_record($urandom_range(0, 2) == 0, addr, port);
    endtask

    task automatic add_bad_prefix();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == sald_pkg::PREFIX_IPV4 || b == sald_pkg::PREFIX_IPV6);
        pkt_q.push_back(b);
    endtask

    // A pause can also switch the parser off for one to four ignored bytes mid-packet.
    task automatic send_packet(input int pause_at, input logic toggle);
        for (int i = 0; i < pkt_q.size(); i++)
        begin
            if (i == pause_at)
            begin
                wait_idle();
                if (toggle)
                begin
                    write_enable(1'b0);
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                    wait_idle();
                    write_enable(1'b1);
                end
            end
            send_byte(pkt_q[i], i == pkt_q.size() - 1);
        end
        packets_sent++;
        pkt_q.delete();
    endtask

    task automatic test_disabled_input();
        add_noise(5);
        send_packet(-1, 1'b0);
        add_noise(1);
        send_packet(-1, 1'b0);
        wait_idle();
        write_enable(1'b1);
    endtask

    task automatic test_header_ends();
        add_noise(1);
        send_packet(-1, 1'b0);
        add_noise(HEADER_BYTES - 1);
        send_packet(-1, 1'b0);
        add_noise(HEADER_BYTES);
        send_packet(-1, 1'b0);
    endtask

    task automatic test_record_forms();
        add_noise(HEADER_BYTES);
        add_record(1'b0, '0, 16'h0001);
        add_record(1'b0, '1, 16'hFFFF);
        add_record(1'b1, '1, 16'h0100);
        add_record(1'b1, '0, 16'h00FF);
        send_packet(-1, 1'b0);
        add_noise(HEADER_BYTES);
        add_record(1'b1, {$urandom, $urandom, $urandom, $urandom}, 16'h1234);
        send_packet(-1, 1'b0);
    endtask

    task automatic test_stop_cases();
        add_noise(HEADER_BYTES);
        add_bad_prefix();
        send_packet(-1, 1'b0);
        add_noise(HEADER_BYTES);
        add_record(1'b0, {4{$urandom}}, 16'hBEEF);
        add_bad_prefix();
        add_noise(5);
        send_packet(-1, 1'b0);
        add_noise(HEADER_BYTES);
        add_record(1'b0, {4{$urandom}}, 16'h0000);
        send_packet(-1, 1'b0);
        add_noise(HEADER_BYTES);
        add_record(1'b1, {4{$urandom}}, 16'h0000);
        add_record(1'b0, {4{$urandom}}, 16'h4321);
        send_packet(-1, 1'b0);
    endtask

    task automatic test_truncation();
        add_noise(HEADER_BYTES);
        pkt_q.push_back(sald_pkg::PREFIX_IPV4);
        send_packet(-1, 1'b0);
        add_noise(HEADER_BYTES);
        add_record(1'b1, {4{$urandom}}, 16'h5555);
        repeat (11) void'(pkt_q.pop_back());
        send_packet(-1, 1'b0);
        add_noise(HEADER_BYTES);
        add_record(1'b0, {4{$urandom}}, 16'hAAAA);
        void'(pkt_q.pop_back());
        send_packet(-1, 1'b0);
    endtask

    task automatic test_enable_toggle();
        add_noise(HEADER_BYTES);
        add_record(1'b0, {4{$urandom}}, 16'h0A0B);
        add_record(1'b1, {4{$urandom}}, 16'h0C0D);
        send_packet(HEADER_BYTES + 3, 1'b1);
        repeat (10) send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_idle();
        write_enable(1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_idle();
        write_enable(1'b1);
        add_noise(HEADER_BYTES);
        add_random_record();
        send_packet(-1, 1'b0);
    endtask

    task automatic test_random_traffic();
        int kind;
        int cut;
        int pause_at;
        while (bytes_parsed < RANDOM_BYTES)
        begin
            if (packets_sent % 10 == 0)
            begin
                case ((packets_sent / 10) % 4)
                    0: begin idle_max = 12; stall_max = 12; end
                    1: begin idle_max = 0; stall_max = 0; end
                    2: begin idle_max = 0; stall_max = 12; end
                    default: begin idle_max = 12; stall_max = 0; end
                endcase
            end
            kind = $urandom_range(0, 99);
            add_noise(HEADER_BYTES);
            repeat ($urandom_range(0, 5)) add_random_record();
            if (kind >= 70 && kind < 80)
            begin
                add_random_record();
                cut = $urandom_range(1, pkt_q.size() - 1);
                while (pkt_q.size() > cut)
                    void'(pkt_q.pop_back());
            end
            else if (kind >= 80 && kind < 88)
            begin
                add_bad_prefix();
                add_noise($urandom_range(0, 6));
            end
            else if (kind >= 88 && kind < 94)
            begin
                add_record($urandom_range(0, 1) == 1,
                           {$urandom, $urandom, $urandom, $urandom}, 16'h0000);
                add_noise($urandom_range(0, 6));
            end
            else if (kind >= 94 && kind < 97)
            begin
                pkt_q.delete();
                add_noise($urandom_range(1, 40));
            end
            if (kind >= 97)
            begin
                wait_idle();
                write_enable(1'b0);
                send_packet(-1, 1'b0);
                wait_idle();
                write_enable(1'b1);
            end
            else
            begin
                pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, pkt_q.size() - 1)
                                                       : -1;
                send_packet(pause_at, $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial
    begin
        accept_en = 1'b0;
        restart_parse();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_input();
        test_header_ends();
        test_record_forms();
        test_stop_cases();
        test_truncation();
        test_enable_toggle();
        test_random_traffic();

        wait_idle();
        repeat (16) @(posedge clk);
        if (predicted_beats.size() != 0)
        begin
            error_count++;
            $display("%0d expected beats never arrived", predicted_beats.size());
        end
        $display("Sent %0d packets (%0d bytes parsed while enabled) with idle and stall mixes.",
                 packets_sent, bytes_parsed);
        $display("Checked %0d address records and %0d status beats; %0d errors.",
                 records_seen, status_seen, error_count);
        if (error_count == 0)
            $display("PASS server_address_list_deframer");
        else
            $display("FAIL server_address_list_deframer");
        $finish;
    end

endmodule
